// ===== sv/cse_pkg.sv =====
package cse_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT  = 2'd3;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               operation;
        logic [3:0]         coef_index;
        logic signed [31:0] value;
    } cse_in_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               out_of_range;
    } cse_out_t;

    // word as it moves down the pipeline
    typedef struct packed {
        logic               op;
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic               flag;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] d;
        logic signed [31:0] e;
    } cse_item_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] a);
        logic signed [31:0] r;
        if (a[32] != a[31])
            r = a[32] ? Q_MIN : Q_MAX;
        else
            r = a[31:0];
        return r;
    endfunction

    // q16 product: drop 16 fraction bits, ties away from zero, then saturate
    function automatic logic signed [31:0] round_sat(input logic signed [64:0] p);
        logic signed [64:0] s;
        logic signed [48:0] q;
        logic signed [31:0] r;
        s = p + (p[64] ? 65'sd32767 : 65'sd32768);
        q = s[64:16];
        if (q[48:31] != {18{q[48]}})
            r = q[48] ? Q_MIN : Q_MAX;
        else
            r = q[31:0];
        return r;
    endfunction

    // c * 0.5 with the same rounding as a product
    function automatic logic signed [31:0] half_round(input logic signed [31:0] c);
        logic [32:0] t;
        logic signed [31:0] r;
        t = {1'b0, c} + 33'd1;
        if (c[31])
            r = {c[31], c[31:1]};
        else
            r = t[32:1];
        return r;
    endfunction

endpackage

// ===== sv/cse_front.sv =====
module cse_front
    import cse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  cse_in_t            in_data,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    input  logic        [31:0] range_scale,
    output logic               item_valid,
    output cse_item_t          item
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    cse_item_t          it1_reg, it2_reg, it3_reg, it4_reg;
    cse_item_t          it1_next, it2_next, it4_next;
    logic signed [64:0] prod_reg;
    logic signed [64:0] prod_next;
    logic signed [32:0] sum;
    logic signed [31:0] mid;
    logic signed [31:0] u_q;

    // clamp, inverted interval tests the low end first
    always_comb
    begin
        it1_next      = '0;
        it1_next.op   = in_data.operation;
        it1_next.idx  = in_data.coef_index;
        it1_next.val  = in_data.value;
        if (in_data.operation == OP_EVAL)
        begin
            if (in_data.value < range_low)
            begin
                it1_next.val  = range_low;
                it1_next.flag = 1'b1;
            end
            else if (in_data.value > range_high)
            begin
                it1_next.val  = range_high;
                it1_next.flag = 1'b1;
            end
        end
    end

    // floor of the midpoint always fits in 32 bits
    assign sum = 33'(range_low) + 33'(range_high);
    assign mid = sum[32:1];

    always_comb
    begin
        it2_next   = it1_reg;
        it2_next.u = sat33(33'(it1_reg.val) - 33'(mid));
    end

    assign prod_next = 65'(it2_reg.u) * 65'($signed({1'b0, range_scale}));

    assign u_q = round_sat(prod_reg);

    always_comb
    begin
        it4_next   = it3_reg;
        it4_next.u = u_q;
        it4_next.v = sat33({u_q, 1'b0});
        it4_next.d = '0;
        it4_next.e = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it1_reg  <= it1_next;
            it2_reg  <= it2_next;
            it3_reg  <= it2_reg;
            prod_reg <= prod_next;
            it4_reg  <= it4_next;
        end
    end

    assign item_valid = v4_reg;
    assign item       = it4_reg;

endmodule

// ===== sv/cse_term.sv =====
module cse_term
    import cse_pkg::*;
#(
    parameter int TERM_INDEX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic [4:0] term_count,
    input  logic       in_valid,
    input  cse_item_t  in_item,
    output logic       out_valid,
    output cse_item_t  out_item
);

    localparam logic [31:0] TI = TERM_INDEX;

    logic               v1_reg, v2_reg, v3_reg;
    cse_item_t          it1_reg, it2_reg, it3_reg;
    cse_item_t          it3_next;
    logic signed [64:0] prod_reg;
    logic signed [64:0] prod_next;
    logic signed [31:0] q_reg;
    logic signed [31:0] coef_reg;
    logic signed [31:0] mul_op;
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic               active;
    logic               coef_wr;

    // the constant term uses u and is always applied
    assign active = (TERM_INDEX == 0) || ({27'd0, term_count} > TI);
    assign mul_op = (TERM_INDEX == 0) ? in_item.u : in_item.v;

    assign prod_next = 65'(mul_op) * 65'(in_item.d);

    assign t1 = sat33(33'(q_reg) - 33'(it2_reg.e));
    assign t2 = sat33(33'(t1) + 33'(coef_reg));

    always_comb
    begin
        it3_next = it2_reg;
        if (active && it2_reg.op == OP_EVAL)
        begin
            it3_next.d = t2;
            it3_next.e = it2_reg.d;
        end
    end

    // coefficient updates at the same place it is read, so order is kept
    assign coef_wr = adv && v2_reg && it2_reg.op == OP_WRITE && {28'd0, it2_reg.idx} == TI;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it1_reg  <= in_item;
            prod_reg <= prod_next;
            it2_reg  <= it1_reg;
            q_reg    <= round_sat(prod_reg);
            it3_reg  <= it3_next;
        end
        if (coef_wr)
            coef_reg <= (TERM_INDEX == 0) ? half_round(it2_reg.val) : it2_reg.val;
    end

    assign out_valid = v3_reg;
    assign out_item  = it3_reg;

endmodule

// ===== sv/chebyshev_series_evaluator.sv =====
// throughput: one word per cycle except during a stall; four front stages, then three stages per term
// (multiply, round, subtract/add) with each term's coefficient held in its own stage
// the whole pipeline stalls only while a result waits on out_ready
// reset clears valid bits and config registers; coefficients are undefined until written
module chebyshev_series_evaluator
    import cse_pkg::*;
#(
    parameter int MAX_TERMS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cse_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cse_out_t             out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic signed [31:0] range_low_reg;
    logic signed [31:0] range_high_reg;
    logic        [31:0] range_scale_reg;
    logic        [4:0]  term_count_reg;
    logic               adv;

    logic      stage_valid [MAX_TERMS+1];
    cse_item_t stage_item  [MAX_TERMS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg   <= 32'sd0;
            range_high_reg  <= 32'sd65536;
            range_scale_reg <= 32'd131072;
            term_count_reg  <= 5'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RANGE_LOW:   range_low_reg   <= cfg_data;
                REG_RANGE_HIGH:  range_high_reg  <= cfg_data;
                REG_RANGE_SCALE: range_scale_reg <= cfg_data;
                REG_TERM_COUNT:  term_count_reg  <= cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    // coefficient writes run through to the end and are dropped there
    assign out_valid = stage_valid[MAX_TERMS] && stage_item[MAX_TERMS].op == OP_EVAL;
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;

    assign out_data.result       = stage_item[MAX_TERMS].d;
    assign out_data.out_of_range = stage_item[MAX_TERMS].flag;

    cse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .range_low   (range_low_reg),
        .range_high  (range_high_reg),
        .range_scale (range_scale_reg),
        .item_valid  (stage_valid[0]),
        .item        (stage_item[0])
    );

    // highest term first, constant term last
    for (genvar k = 0; k < MAX_TERMS; k++)
    begin : g_term
        cse_term #(
            .TERM_INDEX (MAX_TERMS - 1 - k)
        ) u_term (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .term_count (term_count_reg),
            .in_valid   (stage_valid[k]),
            .in_item    (stage_item[k]),
            .out_valid  (stage_valid[k+1]),
            .out_item   (stage_item[k+1])
        );
    end

`ifndef SYNTH
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("pipeline stalled without output backpressure");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(out_data))
        else $error("result changed during stall");

    a_rise_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("result appeared without pipeline advance");
`endif

endmodule
